/* hw/rtl/pulse_induction_motion_detector_top_macros.svh */
// Assertion macros used by the detector checker.
`ifndef PULSE_INDUCTION_MOTION_DETECTOR_TOP_MACROS_SVH
`define PULSE_INDUCTION_MOTION_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIMD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pimd_pkg.sv */
// Shared types and constants of the pulse induction motion detector.
`timescale 1ns / 1ps

package pimd_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int ACC_BITS      = 6;
    localparam int PERIOD_BITS   = 8;
    localparam int STARTUP_BITS  = 16;
    localparam int TONE_BITS     = 12;
    localparam int DIFF_BITS     = 7;
    localparam int OUT_BITS      = 24;

    // result beat layout
    localparam int OUT_BEEP     = 0;
    localparam int OUT_FIRE     = 1;
    localparam int OUT_ERR      = 2;
    localparam int OUT_DIFF_LSB = 3;
    localparam int OUT_TONE_LSB = OUT_DIFF_LSB + DIFF_BITS;

    localparam logic [TONE_BITS-1:0]    TONE_RESET    = 12'd2048;
    localparam logic [TONE_BITS-1:0]    TONE_BASE     = 12'd2049;
    localparam logic [DIFF_BITS-1:0]    DIFF_LIMIT    = 7'd64;
    localparam logic [ACC_BITS-1:0]     ACC_RESET     = 6'd5;
    localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET  = 8'd4;
    localparam logic [STARTUP_BITS-1:0] STARTUP_RESET = 16'd10000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ACCUMULATE   = 2'd0,
        CFG_PULSE_PERIOD = 2'd1,
        CFG_STARTUP      = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_MEASURE = 1'b1
    } t_op;

    // group completion request to the history unit
    typedef struct packed {
        logic finish;
        logic store;
    } t_hist_ctl;

endpackage

/* hw/rtl/pimd_hist.sv */
// History memory, running total and mean of the stored group sums.
`timescale 1ns / 1ps

module pimd_hist #(
    parameter int HISTORY_DEPTH = 32,
    parameter int SUM_BITS      = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pimd_pkg::t_hist_ctl i_ctl,
    input  logic [SUM_BITS-1:0] i_sum,
    output logic [SUM_BITS-1:0] o_mean,
    output logic                o_busy
);
    import pimd_pkg::*;

    localparam int SLOT_BITS  = $clog2(HISTORY_DEPTH);
    localparam int TOT_BITS   = SUM_BITS + SLOT_BITS;
    localparam int SHIFT      = TOT_BITS + SLOT_BITS;
    localparam int RECIP_BITS = TOT_BITS + 1;
    localparam int LO_BITS    = TOT_BITS / 2;
    localparam int HI_BITS    = TOT_BITS - LO_BITS;
    localparam int PLO_BITS   = LO_BITS + RECIP_BITS;
    localparam int PHI_BITS   = HI_BITS + RECIP_BITS;
    localparam int PROD_BITS  = 2 * TOT_BITS + 1;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
    localparam logic [RECIP_BITS-1:0] RECIP     = RECIP_BITS'(RECIP_WIDE);
    localparam logic [SLOT_BITS-1:0]  LAST_SLOT = SLOT_BITS'(HISTORY_DEPTH - 1);

    logic [SUM_BITS-1:0]      r_mem [HISTORY_DEPTH];
    logic [SUM_BITS-1:0]      r_rd_data;
    logic                     r_rd_valid;
    logic [HISTORY_DEPTH-1:0] r_valid;
    logic [SLOT_BITS-1:0]     r_slot, n_slot;
    logic [TOT_BITS-1:0]      r_total, n_total;
    logic [PLO_BITS-1:0]      r_plo;
    logic [PHI_BITS-1:0]      r_phi;
    logic [SUM_BITS-1:0]      r_mean;
    logic                     r_busy1, r_busy2;
    logic                     store;
    logic [SUM_BITS-1:0]      old_entry;
    logic [PROD_BITS-1:0]     prod_sum;

    always_comb begin
        store     = i_ctl.finish && i_ctl.store;
        old_entry = r_rd_valid ? r_rd_data : '0;
        n_slot    = r_slot;
        if (i_ctl.finish) begin
            n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        end
        n_total = r_total;
        if (store) begin
            n_total = r_total - TOT_BITS'(old_entry) + TOT_BITS'(i_sum);
        end
        prod_sum = PROD_BITS'(r_plo) + (PROD_BITS'(r_phi) << LO_BITS);
    end

    // slot always moves on a write, so the prefetch never hits the written entry
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_slot] <= i_sum;
        end
        r_rd_data <= r_mem[n_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_total    <= '0;
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_busy1    <= 1'b1;
            r_busy2    <= 1'b1;
        end else begin
            r_slot     <= n_slot;
            r_total    <= n_total;
            if (store) begin
                r_valid[r_slot] <= 1'b1;
            end
            r_rd_valid <= r_valid[n_slot];
            r_busy1    <= store;
            r_busy2    <= r_busy1;
        end
    end

    // mean = total / depth by exact reciprocal, two partial products
    always_ff @(posedge i_clk) begin
        r_plo  <= PLO_BITS'(r_total[LO_BITS-1:0]) * PLO_BITS'(RECIP);
        r_phi  <= PHI_BITS'(r_total[TOT_BITS-1:LO_BITS]) * PHI_BITS'(RECIP);
        r_mean <= prod_sum[SHIFT +: SUM_BITS];
    end

    assign o_mean = r_mean;
    assign o_busy = r_busy1 || r_busy2;

endmodule

/* hw/rtl/pulse_induction_motion_detector_top.sv */
// Top level of the pulse induction motion detector timing and detection core.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake        Payload
// s_axis    in   tvalid/tready    tuser: op; tdata: pulse_width, coil_timed_out,
//                                 pinpoint_released (LSB first, zero padded)
// m_axis    out  tvalid/tready    tdata: beep_level, fire_pulse, coil_error,
//                                 difference, tone_divider (LSB first, zero padded)
// cfg       in   i_cfg_we         i_cfg_idx selects register, i_cfg_data value
//
// One beat per cycle while tready is high; each beat's result is registered.
// After a group sum is stored in the history the input pauses while the
// two-stage reciprocal multiplier re-forms the history mean, and also after reset.
// A two-entry output stage (register plus skid) lets input flow while m_axis stalls;
// tready drops when both entries hold beats or while the history mean is re-formed.
// Reset is synchronous, active low; history entries read as zero until written.

module pulse_induction_motion_detector_top #(
    parameter int HISTORY_DEPTH = 32,
    parameter int WIDTH_BITS    = 16,
    localparam int IN_BITS      = ((WIDTH_BITS + 2 + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [W-1:0] pulse_width, [W] coil_timed_out, [W+1] pinpoint_released, zero fill
    input  logic [IN_BITS-1:0]                 i_s_axis_tdata,
    // [0] op
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [0] beep_level, [1] fire_pulse, [2] coil_error, [9:3] difference,
    // [21:10] tone_divider, [23:22] zero
    output logic [pimd_pkg::OUT_BITS-1:0]      o_m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [pimd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [pimd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import pimd_pkg::*;

    localparam int SUM_BITS = WIDTH_BITS + ACC_BITS;

    // configuration
    logic [ACC_BITS-1:0]     r_acc_count,    n_acc_count;
    logic [PERIOD_BITS-1:0]  r_pulse_period, n_pulse_period;

    // scalar state
    logic [TONE_BITS-1:0]    r_tone_cnt,     n_tone_cnt;
    logic [TONE_BITS-1:0]    r_tone_reload,  n_tone_reload;
    logic                    r_beep,         n_beep;
    logic [PERIOD_BITS-1:0]  r_pulse_cd,     n_pulse_cd;
    logic [STARTUP_BITS-1:0] r_startup_left, n_startup_left;
    logic [ACC_BITS-1:0]     r_meas_left,    n_meas_left;
    logic [SUM_BITS-1:0]     r_group_sum,    n_group_sum;
    logic [DIFF_BITS-1:0]    r_last_diff,    n_last_diff;

    // output register and skid entry
    logic                    r_out_vld;
    logic [OUT_BITS-1:0]     r_out_data;
    logic                    r_skid_vld;
    logic [OUT_BITS-1:0]     r_skid_data;

    logic                    accept;
    logic                    take;
    t_op                     op;
    logic [WIDTH_BITS-1:0]   pulse_width;
    logic                    coil_timed_out;
    logic                    pinpoint_released;
    logic [SUM_BITS-1:0]     sum_add;
    logic [SUM_BITS-1:0]     gap;
    logic [ACC_BITS-1:0]     meas_dec;
    logic [TONE_BITS-1:0]    tone_dec;
    logic [PERIOD_BITS-1:0]  cd_dec;
    logic [DIFF_BITS-1:0]    rise;
    logic [TONE_BITS-1:0]    reload_new;
    logic                    fire;
    logic                    coil_err;
    logic                    finish;
    logic [OUT_BITS-1:0]     result;
    logic [SUM_BITS-1:0]     hist_mean;
    logic                    hist_busy;
    t_hist_ctl               hist_ctl;

    assign o_s_axis_tready   = !r_skid_vld && !hist_busy;
    assign accept            = i_s_axis_tvalid && o_s_axis_tready;
    assign take              = r_out_vld && i_m_axis_tready;
    assign op                = t_op'(i_s_axis_tuser);
    assign pulse_width       = i_s_axis_tdata[WIDTH_BITS-1:0];
    assign coil_timed_out    = i_s_axis_tdata[WIDTH_BITS];
    assign pinpoint_released = i_s_axis_tdata[WIDTH_BITS+1];

    // rise of the new group sum above the history mean, clamped
    always_comb begin
        sum_add  = r_group_sum + SUM_BITS'(pulse_width);
        meas_dec = r_meas_left - 1'b1;
        tone_dec = r_tone_cnt - 1'b1;
        cd_dec   = r_pulse_cd - 1'b1;
        gap      = sum_add - hist_mean;
        if (sum_add > hist_mean) begin
            rise = (gap > SUM_BITS'(DIFF_LIMIT)) ? DIFF_LIMIT : DIFF_BITS'(gap);
        end else begin
            rise = '0;
        end
        reload_new = TONE_BASE - (TONE_BITS'(rise) << 5);
    end

    always_comb begin
        n_acc_count    = r_acc_count;
        n_pulse_period = r_pulse_period;
        n_tone_cnt     = r_tone_cnt;
        n_tone_reload  = r_tone_reload;
        n_beep         = r_beep;
        n_pulse_cd     = r_pulse_cd;
        n_startup_left = r_startup_left;
        n_meas_left    = r_meas_left;
        n_group_sum    = r_group_sum;
        n_last_diff    = r_last_diff;
        fire           = 1'b0;
        coil_err       = 1'b0;
        finish         = 1'b0;

        if (accept) begin
            case (op)
                OP_TICK: begin
                    // tone counter; at zero it only reloads
                    if (r_tone_cnt != '0) begin
                        if (tone_dec == '0) begin
                            n_beep     = !r_beep;
                            n_tone_cnt = r_tone_reload;
                        end else begin
                            n_tone_cnt = tone_dec;
                        end
                    end else begin
                        n_tone_cnt = r_tone_reload;
                    end
                    // transmit divider parks at zero
                    if (r_pulse_cd != '0) begin
                        if (cd_dec == '0) begin
                            n_pulse_cd = r_pulse_period;
                            fire       = 1'b1;
                        end else begin
                            n_pulse_cd = cd_dec;
                        end
                    end
                    if (r_startup_left != '0) begin
                        n_startup_left = r_startup_left - 1'b1;
                    end
                end
                OP_MEASURE: begin
                    if (coil_timed_out && (r_startup_left == '0)) begin
                        coil_err = 1'b1;
                    end else if (meas_dec == '0) begin
                        finish = 1'b1;
                        if (r_startup_left == '0) begin
                            n_last_diff   = rise;
                            n_tone_reload = reload_new;
                            if (reload_new < r_tone_cnt) begin
                                n_tone_cnt = reload_new;
                            end
                        end
                        n_group_sum = '0;
                        n_meas_left = r_acc_count;
                    end else begin
                        n_group_sum = sum_add;
                        n_meas_left = meas_dec;
                    end
                end
                default: begin
                end
            endcase
        end

        // config writes land only while idle: a rule for the user, unenforced by the block
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ACCUMULATE:   n_acc_count    = i_cfg_data[ACC_BITS-1:0];
                CFG_PULSE_PERIOD: n_pulse_period = i_cfg_data[PERIOD_BITS-1:0];
                CFG_STARTUP:      n_startup_left = i_cfg_data[STARTUP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign hist_ctl.finish = finish;
    assign hist_ctl.store  = pinpoint_released;

    assign result = {2'b00, n_tone_reload, n_last_diff, coil_err, fire, n_beep};

    pimd_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SUM_BITS      (SUM_BITS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hist_ctl),
        .i_sum   (sum_add),
        .o_mean  (hist_mean),
        .o_busy  (hist_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_count    <= ACC_RESET;
            r_pulse_period <= PERIOD_RESET;
            r_tone_cnt     <= TONE_RESET;
            r_tone_reload  <= TONE_RESET;
            r_beep         <= 1'b0;
            r_pulse_cd     <= PERIOD_RESET;
            r_startup_left <= STARTUP_RESET;
            r_meas_left    <= ACC_RESET;
            r_group_sum    <= '0;
            r_last_diff    <= '0;
        end else begin
            r_acc_count    <= n_acc_count;
            r_pulse_period <= n_pulse_period;
            r_tone_cnt     <= n_tone_cnt;
            r_tone_reload  <= n_tone_reload;
            r_beep         <= n_beep;
            r_pulse_cd     <= n_pulse_cd;
            r_startup_left <= n_startup_left;
            r_meas_left    <= n_meas_left;
            r_group_sum    <= n_group_sum;
            r_last_diff    <= n_last_diff;
        end
    end

    // output register with skid: skid fills only when the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (take) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= accept;
            end
        end else if (accept) begin
            if (r_out_vld) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_skid_vld) begin
            r_out_data <= r_skid_data;
        end else if (accept && (take || !r_out_vld)) begin
            r_out_data <= result;
        end
        if (accept && r_out_vld && !take) begin
            r_skid_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* hw/rtl/pimd_checker.sv */
// Port-level checks of the detector top level, bound to it.
`timescale 1ns / 1ps
`include "pulse_induction_motion_detector_top_macros.svh"

module pimd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [pimd_pkg::OUT_BITS-1:0] o_m_axis_tdata
);
    import pimd_pkg::*;

    logic in_beat;
    logic out_stall;

    assign in_beat   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    `PIMD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result beat changed")
    `PIMD_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !o_m_axis_tvalid && !in_beat, !o_m_axis_tvalid, "result beat without input beat")
    `PIMD_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, !o_m_axis_tvalid && in_beat, o_m_axis_tvalid, "accepted beat gave no result")
    `PIMD_ASSERT_NEXT(a_skid_full, i_clk, i_rst_n, out_stall && in_beat, !o_s_axis_tready, "input open with both output entries full")
    `PIMD_ASSERT_SAME(a_diff_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[OUT_DIFF_LSB +: DIFF_BITS] <= DIFF_LIMIT, "difference above limit")

endmodule

bind pulse_induction_motion_detector_top pimd_checker u_pimd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/pulse_induction_motion_detector_top_tb.sv */
// Self-checking stream testbench for the pulse induction motion detector core.
`timescale 1ns / 1ps

module pulse_induction_motion_detector_top_tb;

    import pimd_pkg::*;

    localparam int PW_BITS     = 16;
    localparam int IN_W        = ((PW_BITS + 2 + 7) / 8) * 8;
    localparam int HIST_DEPTH  = 32;
    localparam int STALL_LIMIT = 2000;   // quiet cycles before the run is declared hung
    localparam int SETTLE_GAP  = 6;      // covers the mean refresh with margin
    localparam int RX_HOLD     = 40;     // long sink stall, fills the output skid stage
    localparam int N_PHASES    = 6;

    // one result beat, lowest bit last
    typedef struct packed {
        logic [OUT_BITS-TONE_BITS-DIFF_BITS-4:0] fill;
        logic [TONE_BITS-1:0]                    tone;
        logic [DIFF_BITS-1:0]                    diff;
        logic                                    err;
        logic                                    fire;
        logic                                    beep;
    } reading_t;

    // one line of the directed script: a register write or an input beat
    typedef struct {
        logic               is_cfg;
        t_cfg_idx           idx;
        logic [15:0]        val;
        t_op                op;
        logic [PW_BITS-1:0] pw;
        logic               tmo;
        logic               rel;
        logic               typed;
        reading_t           want;
    } stim_row_t;

    localparam reading_t QUIET_RDG = '{fill: '0, tone: TONE_RESET, diff: '0,
                                       err: 1'b0, fire: 1'b0, beep: 1'b0};
    localparam reading_t FIRE_RDG  = '{fill: '0, tone: TONE_RESET, diff: '0,
                                       err: 1'b0, fire: 1'b1, beep: 1'b0};

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [IN_W-1:0]          i_s_axis_tdata = '0;
    logic                     i_s_axis_tuser = 1'b0;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]      o_m_axis_tdata;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // detector state mirrored by the predictor
    logic [ACC_BITS-1:0]     cfg_acc;
    logic [PERIOD_BITS-1:0]  cfg_period;
    logic [TONE_BITS-1:0]    tone_cnt;
    logic [TONE_BITS-1:0]    tone_rel;
    logic                    beep;
    logic [PERIOD_BITS-1:0]  pulse_cd;
    logic [STARTUP_BITS-1:0] settle_left;
    logic [ACC_BITS-1:0]     meas_left;
    logic [PW_BITS+5:0]      grp_sum;
    logic [PW_BITS+5:0]      hist [HIST_DEPTH];
    logic [PW_BITS+10:0]     hist_total;
    logic [4:0]              hist_slot;
    logic [DIFF_BITS-1:0]    last_diff;

    reading_t readings_due [$];
    int       mismatches = 0;
    int       quiet_cycles = 0;
    bit       idle_on = 1'b1;
    bit       rx_hold_req = 1'b0;

    pulse_induction_motion_detector_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the mirrored detector by one beat and return the reading it gives.
    function automatic reading_t detector_step(t_op op, logic [PW_BITS-1:0] pw,
                                               logic tmo, logic rel);
        reading_t             r;
        logic [PW_BITS+10:0]  mean;
        logic [PW_BITS+10:0]  rise;
        logic                 fire;
        logic                 err;
        fire = 1'b0;
        err  = 1'b0;
        if (op == OP_TICK) begin
            // tone counter: toggle on expiry, reload when already at zero
            if (tone_cnt != 0) begin
                tone_cnt = tone_cnt - 1'b1;
                if (tone_cnt == 0) begin
                    beep     = ~beep;
                    tone_cnt = tone_rel;
                end
            end else begin
                tone_cnt = tone_rel;
            end
            // transmit divider stays parked at zero once the period is zero
            if (pulse_cd != 0) begin
                pulse_cd = pulse_cd - 1'b1;
                if (pulse_cd == 0) begin
                    pulse_cd = cfg_period;
                    fire     = 1'b1;
                end
            end
            if (settle_left != 0)
                settle_left = settle_left - 1'b1;
        end else if (tmo && settle_left == 0) begin
            err = 1'b1;   // late comparator edge after settling: beat dropped
        end else begin
            grp_sum   = grp_sum + pw;
            meas_left = meas_left - 1'b1;
            if (meas_left == 0) begin
                if (settle_left == 0) begin
                    mean = hist_total / (PW_BITS+11)'(HIST_DEPTH);
                    rise = (grp_sum > mean) ? grp_sum - mean : '0;
                    if (rise > DIFF_LIMIT)
                        rise = DIFF_LIMIT;
                    last_diff = rise[DIFF_BITS-1:0];
                    tone_rel  = TONE_BASE - (TONE_BITS'(rise) << 5);
                    if (tone_rel < tone_cnt)
                        tone_cnt = tone_rel;
                end
                if (rel) begin
                    hist_total      = hist_total - hist[hist_slot] + grp_sum;
                    hist[hist_slot] = grp_sum;
                end
                hist_slot = hist_slot + 1'b1;
                grp_sum   = '0;
                meas_left = cfg_acc;
            end
        end
        r      = '0;
        r.beep = beep;
        r.fire = fire;
        r.err  = err;
        r.diff = last_diff;
        r.tone = tone_rel;
        return r;
    endfunction

    function automatic stim_row_t beat_row(t_op op, logic [PW_BITS-1:0] pw, logic tmo,
                                           logic rel, logic typed = 1'b0,
                                           reading_t want = '0);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.idx    = CFG_ACCUMULATE;
        r.val    = '0;
        r.op     = op;
        r.pw     = pw;
        r.tmo    = tmo;
        r.rel    = rel;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(t_cfg_idx idx, logic [15:0] val);
        stim_row_t r;
        r        = beat_row(OP_TICK, '0, 1'b0, 1'b0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one beat, with an optional idle burst first; predict on acceptance.
    task automatic send_beat(t_op op, logic [PW_BITS-1:0] pw, logic tmo, logic rel,
                             logic typed, reading_t want);
        reading_t r;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {{(IN_W-PW_BITS-2){1'b0}}, rel, tmo, pw};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        r = detector_step(op, pw, tmo, rel);
        readings_due.push_back(typed ? want : r);
    endtask

    // Stop offering beats and wait until every predicted reading has come out.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Register writes only with the core idle; settling gap covers the mean refresh.
    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        hold_until_drained();
        repeat (SETTLE_GAP) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ACCUMULATE:   cfg_acc = val[ACC_BITS-1:0];
            CFG_PULSE_PERIOD: cfg_period = val[PERIOD_BITS-1:0];
            CFG_STARTUP:      settle_left = val[STARTUP_BITS-1:0];
            default: ;
        endcase
    endtask

    // Sink: random stall bursts, one long hold on request, none in the final phase.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (RX_HOLD) @(negedge i_clk);
                rx_hold_req = 1'b0;
                i_m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        reading_t got;
        reading_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (readings_due.size() == 0) begin
                $error("unexpected result beat 0x%06h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = readings_due.pop_front();
                check_field("beep_level",   want.beep, got.beep);
                check_field("fire_pulse",   want.fire, got.fire);
                check_field("coil_error",   want.err,  got.err);
                check_field("difference",   want.diff, got.diff);
                check_field("tone_divider", want.tone, got.tone);
            end
        end
    end

    // Watchdog on handshake activity.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** pulse_induction_motion_detector_top: FAILED **");
            $finish;
        end
    end

    initial begin
        stim_row_t          script [$];
        int                 phase_len [N_PHASES];
        logic [15:0]        acc_v;
        logic [15:0]        per_v;
        logic [15:0]        st_v;
        logic [PW_BITS-1:0] base;
        logic [PW_BITS-1:0] pw;
        t_op                op;

        phase_len = '{80, 90, 120, 70, 100, 90};

        // mirror of the reset state
        cfg_acc     = ACC_RESET;
        cfg_period  = PERIOD_RESET;
        tone_cnt    = TONE_RESET;
        tone_rel    = TONE_RESET;
        beep        = 1'b0;
        pulse_cd    = PERIOD_RESET;
        settle_left = STARTUP_RESET;
        meas_left   = ACC_RESET;
        grp_sum     = '0;
        hist_total  = '0;
        hist_slot   = '0;
        last_diff   = '0;
        foreach (hist[i])
            hist[i] = '0;

        // Directed script. Still settling: nothing but the divider moves.
        script.push_back(beat_row(OP_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, QUIET_RDG));
        script.push_back(beat_row(OP_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, QUIET_RDG));
        script.push_back(beat_row(OP_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, QUIET_RDG));
        script.push_back(beat_row(OP_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, FIRE_RDG));
        // timeout while settling is summed like any other width
        script.push_back(beat_row(OP_MEASURE, 16'hFFFF, 1'b1, 1'b1, 1'b1, QUIET_RDG));
        script.push_back(beat_row(OP_MEASURE, 16'h0000, 1'b0, 1'b0, 1'b1, QUIET_RDG));
        script.push_back(beat_row(OP_MEASURE, 16'hAAAA, 1'b0, 1'b1, 1'b1, QUIET_RDG));
        script.push_back(beat_row(OP_MEASURE, 16'h5555, 1'b0, 1'b1, 1'b1, QUIET_RDG));
        // group closes during settling: history written, tone untouched
        script.push_back(beat_row(OP_MEASURE, 16'hFFFF, 1'b0, 1'b1, 1'b1, QUIET_RDG));
        script.push_back(cfg_row(CFG_STARTUP, 16'd3));
        script.push_back(cfg_row(CFG_ACCUMULATE, 16'd4));
        script.push_back(cfg_row(CFG_PULSE_PERIOD, 16'd1));
        for (int i = 0; i < 3; i++)
            script.push_back(beat_row(OP_TICK, 16'h0000, 1'b0, 1'b0));
        // full-scale group: rise clamps, tone reload drops below the running count
        for (int i = 0; i < 5; i++)
            script.push_back(beat_row(OP_MEASURE, 16'hFFFF, 1'b0, 1'b1));
        // timeout after settling flags a coil error
        script.push_back(beat_row(OP_MEASURE, 16'hFFFF, 1'b1, 1'b1));
        for (int i = 0; i < 3; i++)
            script.push_back(beat_row(OP_TICK, 16'h0000, 1'b0, 1'b0));
        // empty group with pinpoint held: zero rise, slowest tone, history kept
        for (int i = 0; i < 4; i++)
            script.push_back(beat_row(OP_MEASURE, 16'h0000, 1'b0, 1'b0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg)
                write_reg(script[i].idx, script[i].val);
            else
                send_beat(script[i].op, script[i].pw, script[i].tmo, script[i].rel,
                          script[i].typed, script[i].want);
        end

        // Random phases; zero period, 64-measurement groups and the longest
        // settling time are among the settings.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin acc_v = 16'd4;  per_v = 16'd1;   st_v = 16'd0;     end
                1: begin acc_v = 16'd63; per_v = 16'd255; st_v = 16'd2;     end
                2: begin acc_v = 16'd0;  per_v = 16'd0;   st_v = 16'd0;     end
                3: begin
                    acc_v = 16'($urandom_range(4, 63));
                    per_v = 16'($urandom_range(1, 255));
                    st_v  = 16'hFFFF;
                end
                4: begin
                    acc_v = 16'($urandom_range(4, 63));
                    per_v = 16'($urandom_range(0, 255));
                    st_v  = 16'($urandom_range(0, 40));
                end
                default: begin acc_v = 16'd5; per_v = 16'd4; st_v = 16'd0; end
            endcase
            idle_on = (p != N_PHASES - 1);
            write_reg(CFG_PULSE_PERIOD, per_v);
            write_reg(CFG_ACCUMULATE, acc_v);
            write_reg(CFG_STARTUP, st_v);
            // small widths keep group sums close to the history mean
            base = PW_BITS'($urandom_range(0, 12));
            for (int k = 0; k < phase_len[p]; k++) begin
                if (p == 1 && k == 30)
                    rx_hold_req = 1'b1;
                if (p == 1 && k == 60)
                    hold_until_drained();
                op = ($urandom_range(0, 9) < 4) ? OP_TICK : OP_MEASURE;
                case ($urandom_range(0, 9))
                    0:       pw = PW_BITS'($urandom_range(0, 16'hFFFF));
                    1, 2:    pw = PW_BITS'($urandom_range(0, 15));
                    default: pw = base + PW_BITS'($urandom_range(0, 3));
                endcase
                send_beat(op, pw, $urandom_range(0, 19) == 0, $urandom_range(0, 6) != 0,
                          1'b0, '0);
            end
        end

        hold_until_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("** pulse_induction_motion_detector_top: PASSED **");
        else
            $display("** pulse_induction_motion_detector_top: FAILED **");
        $finish;
    end

endmodule
